@@ rtl/ssr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the six-axis servo slew ramp.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int AXIS_COUNT = 6;
  localparam int ANGLE_W    = 8;
  localparam int LIMIT_W    = 9;
  localparam int REL_W      = 9;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

  localparam logic [ANGLE_W-1:0] ARM_LOW_RST    = 8'd30;
  localparam logic [ANGLE_W-1:0] ARM_HIGH_RST   = 8'd160;
  localparam logic [ANGLE_W-1:0] ELBOW_LOW_RST  = 8'd30;
  localparam logic [ANGLE_W-1:0] ELBOW_HIGH_RST = 8'd140;
  localparam logic [LIMIT_W-1:0] PAIR_LIMIT_RST = 9'd230;
  localparam logic [ANGLE_W-1:0] GRIP_LOW_RST   = 8'd65;
  localparam logic [ANGLE_W-1:0] GRIP_HIGH_RST  = 8'd170;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    JOINT_BASE    = 3'd0,
    JOINT_ARM     = 3'd1,
    JOINT_ELBOW   = 3'd2,
    JOINT_FOREARM = 3'd3,
    JOINT_WRIST   = 3'd4,
    JOINT_GRIP    = 3'd5
  } joint_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARM_LOW    = 3'd0,
    REG_ARM_HIGH   = 3'd1,
    REG_ELBOW_LOW  = 3'd2,
    REG_ELBOW_HIGH = 3'd3,
    REG_PAIR_LIMIT = 3'd4,
    REG_GRIP_LOW   = 3'd5,
    REG_GRIP_HIGH  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] arm_low;
    logic [ANGLE_W-1:0] arm_high;
    logic [ANGLE_W-1:0] elbow_low;
    logic [ANGLE_W-1:0] elbow_high;
    logic [LIMIT_W-1:0] pair_limit;
    logic [ANGLE_W-1:0] grip_low;
    logic [ANGLE_W-1:0] grip_high;
  } cfg_t;

  typedef logic [AXIS_COUNT-1:0][ANGLE_W-1:0] axis_vec_t;

  typedef struct packed {
    axis_vec_t                tgt;
    logic [ANGLE_W-1:0]       arm_cmd;
    logic [ANGLE_W-1:0]       elbow_cmd;
    logic signed [REL_W-1:0]  arm_rel;
    logic signed [REL_W-1:0]  elbow_rel;
    logic [ANGLE_W-1:0]       accepted;
  } cmd_upd_t;

endpackage

@@ rtl/ssr_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_cfg_regs
// Clamp windows and arm/elbow sum limit, written through the config port.
// ----------------------------------------------------------------------------
module ssr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ssr_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_low    <= ssr_pkg::ARM_LOW_RST;
      cfg.arm_high   <= ssr_pkg::ARM_HIGH_RST;
      cfg.elbow_low  <= ssr_pkg::ELBOW_LOW_RST;
      cfg.elbow_high <= ssr_pkg::ELBOW_HIGH_RST;
      cfg.pair_limit <= ssr_pkg::PAIR_LIMIT_RST;
      cfg.grip_low   <= ssr_pkg::GRIP_LOW_RST;
      cfg.grip_high  <= ssr_pkg::GRIP_HIGH_RST;
    end else if (cfg_we) begin
      unique case (ssr_pkg::cfg_reg_t'(cfg_index))
        ssr_pkg::REG_ARM_LOW:    cfg.arm_low    <= cfg_data[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_ARM_HIGH:   cfg.arm_high   <= cfg_data[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_ELBOW_LOW:  cfg.elbow_low  <= cfg_data[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_ELBOW_HIGH: cfg.elbow_high <= cfg_data[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_PAIR_LIMIT: cfg.pair_limit <= cfg_data[ssr_pkg::LIMIT_W-1:0];
        ssr_pkg::REG_GRIP_LOW:   cfg.grip_low   <= cfg_data[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_GRIP_HIGH:  cfg.grip_high  <= cfg_data[ssr_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/ssr_cmd_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_cmd_map
// Maps one joint command to new targets: clamps, coupled sum limit, offsets.
// ----------------------------------------------------------------------------
module ssr_cmd_map (
  input  ssr_pkg::cfg_t                     cfg,
  input  ssr_pkg::joint_t                   joint,
  input  logic [ssr_pkg::ANGLE_W-1:0]       angle,
  input  ssr_pkg::axis_vec_t                tgt,
  input  logic [ssr_pkg::ANGLE_W-1:0]       arm_cmd,
  input  logic [ssr_pkg::ANGLE_W-1:0]       elbow_cmd,
  input  logic signed [ssr_pkg::REL_W-1:0]  arm_rel,
  input  logic signed [ssr_pkg::REL_W-1:0]  elbow_rel,
  output ssr_pkg::cmd_upd_t                 upd
);

  localparam int SUM_W = ssr_pkg::REL_W + 1;

  localparam logic signed [SUM_W-1:0] ARM_OFFSET     = 10'sd20;
  localparam logic signed [SUM_W-1:0] ELBOW_OFFSET   = 10'sd73;
  localparam logic signed [SUM_W-1:0] FOREARM_OFFSET = 10'sd5;
  localparam logic signed [SUM_W-1:0] WRIST_OFFSET   = 10'sd5;

  typedef struct packed {
    logic [ssr_pkg::ANGLE_W-1:0] d;
    logic [ssr_pkg::ANGLE_W-1:0] other;
  } pair_t;

  function automatic logic [ssr_pkg::ANGLE_W-1:0] clamp_win(
    input logic [ssr_pkg::ANGLE_W-1:0] d,
    input logic [ssr_pkg::ANGLE_W-1:0] lo,
    input logic [ssr_pkg::ANGLE_W-1:0] hi
  );
    logic [ssr_pkg::ANGLE_W-1:0] r;
    priority if (d < lo) r = lo;
    else if (d > hi)     r = hi;
    else                 r = d;
    return r;
  endfunction

  function automatic logic [ssr_pkg::ANGLE_W-1:0] sat_angle(
    input logic signed [SUM_W-1:0] v
  );
    logic [ssr_pkg::ANGLE_W-1:0] r;
    priority if (v < 0)                              r = '0;
    else if (v > $signed({2'b00, ssr_pkg::ANGLE_MAX})) r = ssr_pkg::ANGLE_MAX;
    else                                             r = v[ssr_pkg::ANGLE_W-1:0];
    return r;
  endfunction

  // other command above the limit: new command 0, other lowered to limit
  function automatic pair_t pair_limit(
    input logic [ssr_pkg::ANGLE_W-1:0] d,
    input logic [ssr_pkg::ANGLE_W-1:0] other,
    input logic [ssr_pkg::LIMIT_W-1:0] limit
  );
    pair_t                     r;
    logic [ssr_pkg::LIMIT_W:0] sum;
    logic [ssr_pkg::LIMIT_W:0] diff;
    sum  = {2'b00, d} + {2'b00, other};
    diff = {1'b0, limit} - {2'b00, other};
    r.d     = d;
    r.other = other;
    if (sum > {1'b0, limit}) begin
      if ({1'b0, other} > limit) begin
        r.d     = '0;
        r.other = limit[ssr_pkg::ANGLE_W-1:0];
      end else begin
        r.d = diff[ssr_pkg::ANGLE_W-1:0];
      end
    end
    return r;
  endfunction

  logic [ssr_pkg::ANGLE_W-1:0]       angle_c;
  logic [ssr_pkg::ANGLE_W-1:0]       arm_win;
  logic [ssr_pkg::ANGLE_W-1:0]       elbow_win;
  logic [ssr_pkg::ANGLE_W-1:0]       grip_win;
  pair_t                             arm_pl;
  pair_t                             elbow_pl;
  logic signed [SUM_W-1:0]           angle_s;
  logic signed [SUM_W-1:0]           arm_rel_new;
  logic signed [SUM_W-1:0]           elbow_rel_new;
  logic signed [SUM_W-1:0]           arm_rel_ext;
  logic signed [SUM_W-1:0]           elbow_rel_ext;

  assign angle_c   = (angle > ssr_pkg::ANGLE_MAX) ? ssr_pkg::ANGLE_MAX : angle;
  assign angle_s   = $signed({2'b00, angle_c});
  assign arm_win   = clamp_win(angle_c, cfg.arm_low, cfg.arm_high);
  assign elbow_win = clamp_win(angle_c, cfg.elbow_low, cfg.elbow_high);
  assign grip_win  = clamp_win(angle_c, cfg.grip_low, cfg.grip_high);
  assign arm_pl    = pair_limit(arm_win, elbow_cmd, cfg.pair_limit);
  assign elbow_pl  = pair_limit(elbow_win, arm_cmd, cfg.pair_limit);

  assign arm_rel_new   = $signed({2'b00, arm_pl.d}) - ARM_OFFSET;
  assign elbow_rel_new = $signed({2'b00, elbow_pl.d}) - ELBOW_OFFSET;
  assign arm_rel_ext   = SUM_W'(arm_rel);
  assign elbow_rel_ext = SUM_W'(elbow_rel);

  always_comb begin
    upd.tgt       = tgt;
    upd.arm_cmd   = arm_cmd;
    upd.elbow_cmd = elbow_cmd;
    upd.arm_rel   = arm_rel;
    upd.elbow_rel = elbow_rel;
    upd.accepted  = '0;
    unique case (joint)
      ssr_pkg::JOINT_BASE: begin
        upd.tgt[ssr_pkg::JOINT_BASE] = angle_c;
        upd.accepted                 = angle_c;
      end
      ssr_pkg::JOINT_ARM: begin
        upd.arm_cmd                   = arm_pl.d;
        upd.elbow_cmd                 = arm_pl.other;
        upd.arm_rel                   = arm_rel_new[ssr_pkg::REL_W-1:0];
        upd.tgt[ssr_pkg::JOINT_ARM]   = sat_angle(arm_rel_new);
        upd.tgt[ssr_pkg::JOINT_ELBOW] = sat_angle(arm_rel_new + elbow_rel_ext);
        upd.accepted                  = arm_pl.d;
      end
      ssr_pkg::JOINT_ELBOW: begin
        upd.elbow_cmd                 = elbow_pl.d;
        upd.arm_cmd                   = elbow_pl.other;
        upd.elbow_rel                 = elbow_rel_new[ssr_pkg::REL_W-1:0];
        upd.tgt[ssr_pkg::JOINT_ELBOW] = sat_angle(arm_rel_ext + elbow_rel_new);
        upd.accepted                  = elbow_pl.d;
      end
      ssr_pkg::JOINT_FOREARM: begin
        upd.tgt[ssr_pkg::JOINT_FOREARM] = sat_angle(angle_s - FOREARM_OFFSET);
        upd.accepted                    = angle_c;
      end
      ssr_pkg::JOINT_WRIST: begin
        upd.tgt[ssr_pkg::JOINT_WRIST] = sat_angle(angle_s + WRIST_OFFSET);
        upd.accepted                  = angle_c;
      end
      ssr_pkg::JOINT_GRIP: begin
        upd.tgt[ssr_pkg::JOINT_GRIP] = sat_angle($signed({2'b00, grip_win}));
        upd.accepted                 = grip_win;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/ssr_axis_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_axis_ctrl
// Axis position/target state, one-degree slew per tick, result word build.
// ----------------------------------------------------------------------------
module ssr_axis_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  ssr_pkg::opcode_t                   opcode,
  input  ssr_pkg::joint_t                    joint,
  input  logic [ssr_pkg::ANGLE_W-1:0]        angle,
  input  logic                               contact,
  input  ssr_pkg::cfg_t                      cfg,
  output logic [ssr_pkg::OUT_DATA_W-1:0]     result
);

  localparam int PAD_W = ssr_pkg::OUT_DATA_W - 7 * ssr_pkg::ANGLE_W - 1;

  ssr_pkg::axis_vec_t                pos;
  ssr_pkg::axis_vec_t                tgt;
  logic [ssr_pkg::ANGLE_W-1:0]       arm_cmd;
  logic [ssr_pkg::ANGLE_W-1:0]       elbow_cmd;
  logic signed [ssr_pkg::REL_W-1:0]  arm_rel;
  logic signed [ssr_pkg::REL_W-1:0]  elbow_rel;

  ssr_pkg::axis_vec_t                pos_next;
  ssr_pkg::axis_vec_t                tgt_next;
  logic [ssr_pkg::ANGLE_W-1:0]       arm_cmd_next;
  logic [ssr_pkg::ANGLE_W-1:0]       elbow_cmd_next;
  logic signed [ssr_pkg::REL_W-1:0]  arm_rel_next;
  logic signed [ssr_pkg::REL_W-1:0]  elbow_rel_next;
  logic [ssr_pkg::ANGLE_W-1:0]       accepted;
  logic                              reached;
  ssr_pkg::cmd_upd_t                 upd;

  ssr_cmd_map u_cmd_map (
    .cfg       (cfg),
    .joint     (joint),
    .angle     (angle),
    .tgt       (tgt),
    .arm_cmd   (arm_cmd),
    .elbow_cmd (elbow_cmd),
    .arm_rel   (arm_rel),
    .elbow_rel (elbow_rel),
    .upd       (upd)
  );

  always_comb begin
    pos_next       = pos;
    tgt_next       = tgt;
    arm_cmd_next   = arm_cmd;
    elbow_cmd_next = elbow_cmd;
    arm_rel_next   = arm_rel;
    elbow_rel_next = elbow_rel;
    accepted       = '0;
    unique case (opcode)
      ssr_pkg::OP_SET: begin
        tgt_next       = upd.tgt;
        arm_cmd_next   = upd.arm_cmd;
        elbow_cmd_next = upd.elbow_cmd;
        arm_rel_next   = upd.arm_rel;
        elbow_rel_next = upd.elbow_rel;
        accepted       = upd.accepted;
      end
      ssr_pkg::OP_TICK: begin
        // gripper closing onto an object holds where it is
        if (contact && tgt[ssr_pkg::JOINT_GRIP] < pos[ssr_pkg::JOINT_GRIP])
          tgt_next[ssr_pkg::JOINT_GRIP] = pos[ssr_pkg::JOINT_GRIP];
        for (int i = 0; i < ssr_pkg::AXIS_COUNT; i++) begin
          if (pos[i] < tgt_next[i])      pos_next[i] = pos[i] + 1'b1;
          else if (pos[i] > tgt_next[i]) pos_next[i] = pos[i] - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign reached = (pos_next == tgt_next);

  assign result = {
    {PAD_W{1'b0}},
    accepted,
    reached,
    ssr_pkg::ANGLE_MAX - pos_next[ssr_pkg::JOINT_GRIP],
    pos_next[ssr_pkg::JOINT_WRIST],
    pos_next[ssr_pkg::JOINT_FOREARM],
    ssr_pkg::ANGLE_MAX - pos_next[ssr_pkg::JOINT_ELBOW],
    pos_next[ssr_pkg::JOINT_ARM],
    pos_next[ssr_pkg::JOINT_BASE]
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      tgt       <= '0;
      arm_cmd   <= '0;
      elbow_cmd <= '0;
      arm_rel   <= '0;
      elbow_rel <= '0;
    end else if (accept) begin
      pos       <= pos_next;
      tgt       <= tgt_next;
      arm_cmd   <= arm_cmd_next;
      elbow_cmd <= elbow_cmd_next;
      arm_rel   <= arm_rel_next;
      elbow_rel <= elbow_rel_next;
    end
  end

endmodule

@@ rtl/ssr_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_out_buf
// Two-deep result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module ssr_out_buf (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ssr_pkg::OUT_DATA_W-1:0]  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ssr_pkg::OUT_DATA_W-1:0]  out_data
);

  logic                            skid_valid;
  logic [ssr_pkg::OUT_DATA_W-1:0]  skid_data;
  logic                            load;
  logic                            out_free;

  assign in_ready = !skid_valid;
  assign load     = in_valid && !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || load;
      skid_valid <= 1'b0;
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_data <= skid_data;
      else if (load)  out_data <= in_data;
    end else if (load) begin
      skid_data <= in_data;
    end
  end

endmodule

@@ rtl/six_axis_servo_slew_ramp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_axis_servo_slew_ramp
// Six-channel servo target mapper and one-degree-per-tick slew ramp.
// ----------------------------------------------------------------------------
// One beat is taken every clock cycle while s_tready is high. Each tick or
// set beat is handled by a single combinational pass over the axis state
// registers; its result is registered into a two-deep output buffer (skid
// entry while the output register waits), so the input keeps flowing while one
// result waits; the slave side stalls only once both buffer entries are full.
// Axis, config and valid state reset at once, with no clearing pass. Config writes
// are taken at any time but should only be made while the block is idle.
module six_axis_servo_slew_ramp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] angle, [8] contact, [15:9] zero
  input  logic [ssr_pkg::IN_DATA_W-1:0]   s_tdata,
  // [0] opcode, [3:1] joint
  input  logic [ssr_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] base_drive, [15:8] arm_drive, [23:16] elbow_drive,
  // [31:24] forearm_drive, [39:32] wrist_drive, [47:40] grip_drive,
  // [48] all_reached, [56:49] accepted_command, [63:57] zero
  output logic [ssr_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ssr_pkg::cfg_t                    cfg;
  logic                             accept;
  logic [ssr_pkg::OUT_DATA_W-1:0]   result;

  assign accept = s_tvalid && s_tready;

  ssr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssr_axis_ctrl u_axis_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .opcode  (ssr_pkg::opcode_t'(s_tuser[0])),
    .joint   (ssr_pkg::joint_t'(s_tuser[3:1])),
    .angle   (s_tdata[ssr_pkg::ANGLE_W-1:0]),
    .contact (s_tdata[ssr_pkg::ANGLE_W]),
    .cfg     (cfg),
    .result  (result)
  );

  ssr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

@@ rtl/ssr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks for the servo slew ramp, bound to the top level.
// ----------------------------------------------------------------------------
module ssr_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [ssr_pkg::OUT_DATA_W-1:0]  m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // an accepted beat with nothing buffered shows up the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> m_tvalid)
    else $error("beat lost or late through empty buffer");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] <= 8'd180) && (m_tdata[15:8] <= 8'd180) &&
                 (m_tdata[23:16] <= 8'd180) && (m_tdata[31:24] <= 8'd180) &&
                 (m_tdata[39:32] <= 8'd180) && (m_tdata[47:40] <= 8'd180))
    else $error("servo drive outside 0..180");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

endmodule

bind six_axis_servo_slew_ramp ssr_checker u_ssr_checker (.*);

@@ verif/tb_six_axis_servo_slew_ramp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_axis_servo_slew_ramp
// Self-checking bench for the six-axis servo slew ramp.
// ----------------------------------------------------------------------------
// A behavioural model of the joint mapping and slew ramp predicts the six
// drives, the settled flag and the clamped command for every accepted beat.
// A short directed run covers clamping, offsets, saturation, the coupled
// pair limit, ignored joints and the gripper contact freeze. Random phases
// then run under several limit settings with bursty input and a stalling
// output side. Output beats are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_six_axis_servo_slew_ramp;

  localparam int ARM_OFFSET     = 20;
  localparam int ELBOW_OFFSET   = 73;
  localparam int FOREARM_OFFSET = 5;
  localparam int WRIST_OFFSET   = 5;
  localparam int PHASE_BEATS    = 75;

  localparam logic [2:0] JOINT_SPARE_A = 3'd6;
  localparam logic [2:0] JOINT_SPARE_B = 3'd7;

  typedef struct {
    logic [ssr_pkg::ANGLE_W-1:0] base;
    logic [ssr_pkg::ANGLE_W-1:0] arm;
    logic [ssr_pkg::ANGLE_W-1:0] elbow;
    logic [ssr_pkg::ANGLE_W-1:0] forearm;
    logic [ssr_pkg::ANGLE_W-1:0] wrist;
    logic [ssr_pkg::ANGLE_W-1:0] grip;
    logic                        reached;
    logic [ssr_pkg::ANGLE_W-1:0] accepted;
  } servo_drive_t;

  class servo_drive_board;
    int unsigned arm_lo, arm_hi, elbow_lo, elbow_hi, pair_lim, grip_lo, grip_hi;
    int unsigned pos[ssr_pkg::AXIS_COUNT];
    int unsigned tgt[ssr_pkg::AXIS_COUNT];
    int unsigned arm_cmd, elbow_cmd;
    int          arm_rel, elbow_rel;
    servo_drive_t drive_q[$];
    int unsigned errors, n_ticks, n_sets, n_ignored, n_frozen, n_capped;
    int unsigned n_checked, n_settled;

    function new();
      arm_lo   = ssr_pkg::ARM_LOW_RST;
      arm_hi   = ssr_pkg::ARM_HIGH_RST;
      elbow_lo = ssr_pkg::ELBOW_LOW_RST;
      elbow_hi = ssr_pkg::ELBOW_HIGH_RST;
      pair_lim = ssr_pkg::PAIR_LIMIT_RST;
      grip_lo  = ssr_pkg::GRIP_LOW_RST;
      grip_hi  = ssr_pkg::GRIP_HIGH_RST;
      foreach (pos[i]) begin
        pos[i] = 0;
        tgt[i] = 0;
      end
      arm_cmd   = 0;
      elbow_cmd = 0;
      arm_rel   = 0;
      elbow_rel = 0;
    endfunction

    function void set_reg(ssr_pkg::cfg_reg_t idx, logic [ssr_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ssr_pkg::REG_ARM_LOW:    arm_lo   = val[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_ARM_HIGH:   arm_hi   = val[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_ELBOW_LOW:  elbow_lo = val[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_ELBOW_HIGH: elbow_hi = val[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_PAIR_LIMIT: pair_lim = val;
        ssr_pkg::REG_GRIP_LOW:   grip_lo  = val[ssr_pkg::ANGLE_W-1:0];
        ssr_pkg::REG_GRIP_HIGH:  grip_hi  = val[ssr_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned sat_deg(int v);
      if (v < 0) return 0;
      if (v > ssr_pkg::ANGLE_MAX) return ssr_pkg::ANGLE_MAX;
      return v;
    endfunction

    // inverted window: a value below the low bound gets low, any other gets high
    function int unsigned window(int unsigned d, int unsigned lo, int unsigned hi);
      if (d < lo) return lo;
      if (d > hi) return hi;
      return d;
    endfunction

    function int unsigned pair_cap(int unsigned d, inout int unsigned other);
      if (d + other > pair_lim) begin
        n_capped++;
        if (other > pair_lim) begin
          d = 0;
          other = pair_lim;
        end else begin
          d = pair_lim - other;
        end
      end
      return d;
    endfunction

    function bit all_at_target();
      foreach (pos[i])
        if (pos[i] != tgt[i]) return 1'b0;
      return 1'b1;
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction

    function void predict_drives(ssr_pkg::opcode_t op, logic [2:0] jnt,
                                 logic [7:0] ang, logic cont);
      int unsigned a, d, acc;
      servo_drive_t want;
      a = (ang > ssr_pkg::ANGLE_MAX) ? ssr_pkg::ANGLE_MAX : ang;
      acc = 0;
      if (op == ssr_pkg::OP_SET) begin
        n_sets++;
        case (jnt)
          ssr_pkg::JOINT_BASE: begin
            tgt[0] = a;
            acc = a;
          end
          ssr_pkg::JOINT_ARM: begin
            d = pair_cap(window(a, arm_lo, arm_hi), elbow_cmd);
            arm_cmd = d;
            arm_rel = int'(d) - ARM_OFFSET;
            tgt[1] = sat_deg(arm_rel);
            tgt[2] = sat_deg(arm_rel + elbow_rel);
            acc = d;
          end
          ssr_pkg::JOINT_ELBOW: begin
            d = pair_cap(window(a, elbow_lo, elbow_hi), arm_cmd);
            elbow_cmd = d;
            elbow_rel = int'(d) - ELBOW_OFFSET;
            tgt[2] = sat_deg(arm_rel + elbow_rel);
            acc = d;
          end
          ssr_pkg::JOINT_FOREARM: begin
            tgt[3] = sat_deg(int'(a) - FOREARM_OFFSET);
            acc = a;
          end
          ssr_pkg::JOINT_WRIST: begin
            tgt[4] = sat_deg(int'(a) + WRIST_OFFSET);
            acc = a;
          end
          ssr_pkg::JOINT_GRIP: begin
            d = window(a, grip_lo, grip_hi);
            tgt[5] = sat_deg(d);
            acc = d;
          end
          default: n_ignored++;
        endcase
      end else begin
        n_ticks++;
        // contact while closing holds the gripper where it is
        if (cont && tgt[5] < pos[5]) begin
          tgt[5] = pos[5];
          n_frozen++;
        end
        foreach (pos[i]) begin
          if (pos[i] < tgt[i]) pos[i]++;
          else if (pos[i] > tgt[i]) pos[i]--;
        end
      end
      want.base     = pos[0];
      want.arm      = pos[1];
      want.elbow    = ssr_pkg::ANGLE_MAX - pos[2];
      want.forearm  = pos[3];
      want.wrist    = pos[4];
      want.grip     = ssr_pkg::ANGLE_MAX - pos[5];
      want.reached  = all_at_target();
      want.accepted = acc;
      drive_q.push_back(want);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [ssr_pkg::OUT_DATA_W-1:0] d);
      servo_drive_t want;
      if (drive_q.size() == 0) begin
        $error("result beat with nothing expected: %h", d);
        errors++;
        return;
      end
      want = drive_q.pop_front();
      n_checked++;
      if (want.reached) n_settled++;
      check_field("base_drive",       want.base,        d[7:0]);
      check_field("arm_drive",        want.arm,         d[15:8]);
      check_field("elbow_drive",      want.elbow,       d[23:16]);
      check_field("forearm_drive",    want.forearm,     d[31:24]);
      check_field("wrist_drive",      want.wrist,       d[39:32]);
      check_field("grip_drive",       want.grip,        d[47:40]);
      check_field("all_reached",      {7'd0, want.reached}, {7'd0, d[48]});
      check_field("accepted_command", want.accepted,    d[56:49]);
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ssr_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [ssr_pkg::IN_USER_W-1:0]  s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [ssr_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we;
  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data;

  servo_drive_board drives = new();
  int burst_left;
  bit gaps_on;

  six_axis_servo_slew_ramp dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_six_axis_servo_slew_ramp NOT OK");
    $finish;
  end

  // output side: stall pattern switches between random modes
  initial begin
    int mode;
    int left;
    m_tready <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 11) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) drives.check_result(m_tdata);
  end

  task automatic send_beat(input ssr_pkg::opcode_t op, input logic [2:0] jnt,
                           input logic [7:0] ang, input logic cont);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, cont, ang};
    s_tuser  <= {jnt, op};
    do @(posedge clk); while (!s_tready);
    drives.predict_drives(op, jnt, ang, cont);
  endtask

  task automatic pause_beats(input int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic paced_beat(input ssr_pkg::opcode_t op, input logic [2:0] jnt,
                            input logic [7:0] ang, input logic cont);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      pause_beats($urandom_range(1, 6));
    end
    if (burst_left > 0) burst_left--;
    send_beat(op, jnt, ang, cont);
  endtask

  task automatic hold_until_empty();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (drives.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input ssr_pkg::cfg_reg_t idx,
                           input logic [ssr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    drives.set_reg(idx, val);
  endtask

  task automatic load_limits(input int a_lo, input int a_hi, input int e_lo,
                             input int e_hi, input int lim, input int g_lo,
                             input int g_hi);
    write_reg(ssr_pkg::REG_ARM_LOW,    9'(a_lo));
    write_reg(ssr_pkg::REG_ARM_HIGH,   9'(a_hi));
    write_reg(ssr_pkg::REG_ELBOW_LOW,  9'(e_lo));
    write_reg(ssr_pkg::REG_ELBOW_HIGH, 9'(e_hi));
    write_reg(ssr_pkg::REG_PAIR_LIMIT, 9'(lim));
    write_reg(ssr_pkg::REG_GRIP_LOW,   9'(g_lo));
    write_reg(ssr_pkg::REG_GRIP_HIGH,  9'(g_hi));
  endtask

  initial begin
    ssr_pkg::opcode_t op;
    logic [2:0]       jnt;
    logic [7:0]       ang;
    int               pick;
    int               n;
    int               sent;
    bit               held;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= ssr_pkg::REG_ARM_LOW;
    cfg_data  <= '0;
    burst_left = 0;
    gaps_on    = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset limits: saturation, clamps, offsets, pair cap, spare joints
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_BASE,    8'd255, 1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_FOREARM, 8'd0,   1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_WRIST,   8'd180, 1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_ARM,     8'd200, 1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_ELBOW,   8'd255, 1'b1);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_GRIP,    8'd255, 1'b0);
    send_beat(ssr_pkg::OP_SET,  JOINT_SPARE_A,          8'd90,  1'b0);
    send_beat(ssr_pkg::OP_SET,  JOINT_SPARE_B,          8'd90,  1'b1);
    send_beat(ssr_pkg::OP_TICK, ssr_pkg::JOINT_BASE,    8'd0,   1'b1);
    send_beat(ssr_pkg::OP_TICK, ssr_pkg::JOINT_GRIP,    8'd77,  1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_ARM,     8'd0,   1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_GRIP,    8'd0,   1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_FOREARM, 8'd180, 1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_BASE,    8'd0,   1'b0);
    send_beat(ssr_pkg::OP_TICK, ssr_pkg::JOINT_BASE,    8'd0,   1'b0);

    // widest limits: gripper freeze on contact, arm below its offset
    hold_until_empty();
    load_limits(0, 180, 0, 180, 360, 0, 180);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_GRIP,  8'd4, 1'b0);
    repeat (3) send_beat(ssr_pkg::OP_TICK, ssr_pkg::JOINT_BASE, 8'd0, 1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_GRIP,  8'd0, 1'b0);
    send_beat(ssr_pkg::OP_TICK, ssr_pkg::JOINT_BASE,  8'd0, 1'b1);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_ARM,   8'd5, 1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_ARM,   8'd170, 1'b0);
    send_beat(ssr_pkg::OP_SET,  ssr_pkg::JOINT_ELBOW, 8'd150, 1'b0);

    // limit dropped below the stored arm command
    hold_until_empty();
    write_reg(ssr_pkg::REG_PAIR_LIMIT, 9'd100);
    send_beat(ssr_pkg::OP_SET, ssr_pkg::JOINT_ELBOW, 8'd50, 1'b0);
    send_beat(ssr_pkg::OP_SET, ssr_pkg::JOINT_ARM,   8'd90, 1'b0);

    for (int p = 0; p < 6; p++) begin
      hold_until_empty();
      case (p)
        0: load_limits(0, 180, 0, 180, 0, 0, 180);
        1: load_limits(150, 40, 170, 10, 200, 180, 0);
        3: load_limits(int'(ssr_pkg::ARM_LOW_RST), int'(ssr_pkg::ARM_HIGH_RST),
                       int'(ssr_pkg::ELBOW_LOW_RST), int'(ssr_pkg::ELBOW_HIGH_RST),
                       int'(ssr_pkg::PAIR_LIMIT_RST), int'(ssr_pkg::GRIP_LOW_RST),
                       int'(ssr_pkg::GRIP_HIGH_RST));
        5: load_limits(0, 180, 0, 180, 360, 0, 180);
        default: load_limits($urandom_range(0, 180), $urandom_range(0, 180),
                             $urandom_range(0, 180), $urandom_range(0, 180),
                             $urandom_range(0, 360), $urandom_range(0, 180),
                             $urandom_range(0, 180));
      endcase
      gaps_on = (p != 3);
      burst_left = 0;
      sent = 0;
      held = 1'b0;
      while (sent < PHASE_BEATS) begin
        if (!held && sent >= 40 && p[0]) begin
          hold_until_empty();
          held = 1'b1;
        end
        if ($urandom_range(0, 29) == 0) begin
          // tick until everything settles, bounded
          n = 0;
          while (!drives.all_at_target() && n < 40 && sent < PHASE_BEATS) begin
            paced_beat(ssr_pkg::OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom), 1'b0);
            n++;
            sent++;
          end
        end else begin
          op = ($urandom_range(0, 99) < 48) ? ssr_pkg::OP_TICK : ssr_pkg::OP_SET;
          jnt = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
          pick = $urandom_range(0, 99);
          if (pick < 12) ang = 8'd0;
          else if (pick < 22) ang = ssr_pkg::ANGLE_MAX;
          else if (pick < 35) ang = 8'($urandom_range(181, 255));
          else ang = 8'($urandom_range(0, 180));
          paced_beat(op, jnt, ang, 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end

    hold_until_empty();
    repeat (5) @(posedge clk);
    if (drives.pending() != 0) begin
      $error("%0d expected result beats never arrived", drives.pending());
      drives.errors++;
    end
    $display("Run: %0d tick beats (%0d gripper holds), %0d set beats (%0d pair caps, %0d %s",
             drives.n_ticks, drives.n_frozen, drives.n_sets, drives.n_capped,
             drives.n_ignored, "spare joints).");
    $display("Checked %0d result beats, %0d with all axes settled, %s",
             drives.n_checked, drives.n_settled, "over seven limit settings.");
    if (drives.errors == 0) begin
      $display("tb_six_axis_servo_slew_ramp OK");
    end else begin
      $display("tb_six_axis_servo_slew_ramp NOT OK");
    end
    $finish;
  end

endmodule
